// ----- hdl/mgct_pkg.sv -----
// ----------------------------------------------------------------------------
// mgct_pkg
// types, command codes and sizing for the multicast group configuration table
// ----------------------------------------------------------------------------
package mgct_pkg;

   // table geometry
   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int NUM_W       = 7;
   localparam int SLOT_CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int CMP_W       = (SLOT_CNT_W > NUM_W) ? SLOT_CNT_W : NUM_W;

   // command codes
   localparam logic [2:0] CMD_ADD        = 3'd0;
   localparam logic [2:0] CMD_UPDATE     = 3'd1;
   localparam logic [2:0] CMD_DELETE     = 3'd2;
   localparam logic [2:0] CMD_READ       = 3'd3;
   localparam logic [2:0] CMD_VLAN_BY_GRP = 3'd4;
   localparam logic [2:0] CMD_EXISTS     = 3'd5;
   localparam logic [2:0] CMD_VLAN_USED  = 3'd6;
   localparam logic [2:0] CMD_GRP_CONFL  = 3'd7;

   typedef struct packed {
      logic [2:0]       cmd;
      logic [NUM_W-1:0] slot_index;
      logic [31:0]      group_address;
      logic [11:0]      vlan_id;
      logic [31:0]      source_address;
      logic [31:0]      assured_bw;
      logic [31:0]      peak_bw;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] out_vlan;
      logic [31:0] out_group;
      logic [31:0] out_source;
      logic [31:0] out_assured_bw;
      logic [31:0] out_peak_bw;
   } rsp_type;

   // one table entry as held in the store
   typedef struct packed {
      logic [31:0] group;
      logic [11:0] vlan;
      logic [31:0] source;
      logic [31:0] assured_bw;
      logic [31:0] peak_bw;
   } entry_type;

   // key and skip settings for the compare unit
   typedef struct packed {
      logic             vlan_mode;
      logic             skip_en;
      logic [CMP_W-1:0] skip_num;
      logic [31:0]      group;
      logic [11:0]      vlan;
   } match_ctl_type;

endpackage

// ----- hdl/mgct_store.sv -----
// ----------------------------------------------------------------------------
// mgct_store
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mgct_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [mgct_pkg::SLOT_W-1:0] wr_addr,
   input  mgct_pkg::entry_type        wr_data,
   input  logic [mgct_pkg::SLOT_W-1:0] rd_addr,
   output mgct_pkg::entry_type        rd_data
);

   mgct_pkg::entry_type store_ff [mgct_pkg::TABLE_SLOTS];
   mgct_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mgct_match.sv -----
// ----------------------------------------------------------------------------
// mgct_match
// shared compare unit: tests one entry against the search key
// ----------------------------------------------------------------------------
module mgct_match (
   input  mgct_pkg::entry_type        entry,
   input  logic                       entry_valid,
   input  logic [mgct_pkg::SLOT_W-1:0] entry_idx,
   input  mgct_pkg::match_ctl_type    ctl,
   output logic                       hit
);

   logic [mgct_pkg::CMP_W-1:0] idx_num;
   logic                       skip;
   logic                       key_eq;

   // slot numbers count from one
   assign idx_num = mgct_pkg::CMP_W'(entry_idx) + mgct_pkg::CMP_W'(1);
   assign skip    = ctl.skip_en && (idx_num == ctl.skip_num);
   assign key_eq  = ctl.vlan_mode ? (entry.vlan == ctl.vlan) : (entry.group == ctl.group);
   assign hit     = entry_valid && !skip && key_eq;

endmodule

// ----- hdl/multicast_group_config_table.sv -----
// ----------------------------------------------------------------------------
// multicast_group_config_table
// slot table of multicast group entries with key search by linear scan
// ----------------------------------------------------------------------------
//
//   channel   ports                      direction   handshake
//   request   start, busy, req_item      in          taken when start and not busy
//   response  rsp_strobe, rsp_item       out         one cycle, no back-pressure
//
// a command that searches the table (add, update, vlan by group,
// exists, vlan in use, group conflict) scans the slots one per cycle through
// the single store read port and the shared compare unit, and stops early on a
// hit; read passes through the read and done states, delete only through done;
// the response word follows the last busy cycle
// reset clears the valid marks and the sequencer; entry contents are not reset
// the receiver cannot stall: the response word is shown for one cycle only
// ----------------------------------------------------------------------------
module multicast_group_config_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mgct_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mgct_pkg::rsp_type rsp_item
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_READ = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [mgct_pkg::SLOT_W-1:0] LAST_SLOT =
      mgct_pkg::SLOT_W'(mgct_pkg::TABLE_SLOTS - 1);

   // sequencer and pipeline registers
   state_type                   state_ff, state_in;
   mgct_pkg::req_type           req_ff, req_in;
   logic [mgct_pkg::SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic                        last_issued_ff, last_issued_in;
   logic                        data_vld_ff, data_vld_in;
   logic [mgct_pkg::SLOT_W-1:0] data_idx_ff, data_idx_in;
   logic                        found_ff, found_in;
   logic [11:0]                 found_vlan_ff, found_vlan_in;
   logic                        valid_ff [mgct_pkg::TABLE_SLOTS];
   logic                        valid_in [mgct_pkg::TABLE_SLOTS];
   logic                        rsp_strobe_ff, rsp_strobe_in;
   mgct_pkg::rsp_type           rsp_item_ff, rsp_item_in;

   // decode of the new request word
   logic [mgct_pkg::CMP_W-1:0]  new_num;
   logic [mgct_pkg::SLOT_W-1:0] new_slot;
   logic                        new_is_scan;

   // decode of the held request word
   logic [mgct_pkg::CMP_W-1:0]  cur_num;
   logic [mgct_pkg::SLOT_W-1:0] cur_slot;
   logic                        cur_slot_ok;
   logic                        cur_slot_valid;

   // store and compare unit
   logic                        wr_en;
   mgct_pkg::entry_type         wr_data;
   mgct_pkg::entry_type         rd_data;
   mgct_pkg::match_ctl_type     match_ctl;
   logic                        hit;

   assign new_num     = mgct_pkg::CMP_W'(req_item.slot_index);
   assign new_slot    = mgct_pkg::SLOT_W'(new_num - mgct_pkg::CMP_W'(1));
   assign new_is_scan = (req_item.cmd != mgct_pkg::CMD_DELETE) &&
                        (req_item.cmd != mgct_pkg::CMD_READ);

   assign cur_num        = mgct_pkg::CMP_W'(req_ff.slot_index);
   assign cur_slot       = mgct_pkg::SLOT_W'(cur_num - mgct_pkg::CMP_W'(1));
   assign cur_slot_ok    = (cur_num != '0) &&
                           (cur_num <= mgct_pkg::CMP_W'(mgct_pkg::TABLE_SLOTS));
   assign cur_slot_valid = cur_slot_ok && valid_ff[cur_slot];

   // search key: vlan in use compares vlans, everything else compares groups
   // only the two checks honour a skip slot
   assign match_ctl.vlan_mode = (req_ff.cmd == mgct_pkg::CMD_VLAN_USED);
   assign match_ctl.skip_en   = (req_ff.cmd == mgct_pkg::CMD_VLAN_USED) ||
                                (req_ff.cmd == mgct_pkg::CMD_GRP_CONFL);
   assign match_ctl.skip_num  = cur_num;
   assign match_ctl.group     = req_ff.group_address;
   assign match_ctl.vlan      = req_ff.vlan_id;

   assign wr_data.group      = req_ff.group_address;
   assign wr_data.vlan       = req_ff.vlan_id;
   assign wr_data.source     = req_ff.source_address;
   assign wr_data.assured_bw = req_ff.assured_bw;
   assign wr_data.peak_bw    = req_ff.peak_bw;

   mgct_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_slot),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   mgct_match u_match (
      .entry       (rd_data),
      .entry_valid (valid_ff[data_idx_ff]),
      .entry_idx   (data_idx_ff),
      .ctl         (match_ctl),
      .hit         (hit)
   );

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      scan_idx_in    = scan_idx_ff;
      last_issued_in = last_issued_ff;
      data_vld_in    = data_vld_ff;
      data_idx_in    = data_idx_ff;
      found_in       = found_ff;
      found_vlan_in  = found_vlan_ff;
      valid_in       = valid_ff;
      rsp_strobe_in  = 1'b0;
      rsp_item_in    = '0;
      wr_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in         = req_item;
               found_in       = 1'b0;
               found_vlan_in  = '0;
               data_vld_in    = 1'b0;
               last_issued_in = 1'b0;
               if (new_is_scan) begin
                  scan_idx_in = '0;
                  state_in    = ST_SCAN;
               end else if (req_item.cmd == mgct_pkg::CMD_READ) begin
                  // point the read port at the slot, data comes back in done
                  scan_idx_in = new_slot;
                  state_in    = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_SCAN: begin
            // issue the next slot address to the store
            data_vld_in = !last_issued_ff;
            data_idx_in = scan_idx_ff;
            if (!last_issued_ff) begin
               if (scan_idx_ff == LAST_SLOT) begin
                  last_issued_in = 1'b1;
               end else begin
                  scan_idx_in = scan_idx_ff + mgct_pkg::SLOT_W'(1);
               end
            end
            // first hit ends the search
            if (data_vld_ff && hit) begin
               found_in      = 1'b1;
               found_vlan_in = rd_data.vlan;
               state_in      = ST_DONE;
            end else if (data_vld_ff && (data_idx_ff == LAST_SLOT)) begin
               state_in = ST_DONE;
            end
         end

         ST_READ: begin
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (req_ff.cmd)
               mgct_pkg::CMD_ADD: begin
                  rsp_item_in.ok = cur_slot_ok && !found_ff && !valid_ff[cur_slot];
                  if (rsp_item_in.ok) begin
                     wr_en              = 1'b1;
                     valid_in[cur_slot] = 1'b1;
                  end
               end
               mgct_pkg::CMD_UPDATE: begin
                  rsp_item_in.ok = cur_slot_valid && found_ff;
                  wr_en          = rsp_item_in.ok;
               end
               mgct_pkg::CMD_DELETE: begin
                  rsp_item_in.ok = cur_slot_valid;
                  if (cur_slot_valid) begin
                     valid_in[cur_slot] = 1'b0;
                  end
               end
               mgct_pkg::CMD_READ: begin
                  rsp_item_in.ok = cur_slot_valid;
                  if (cur_slot_valid) begin
                     rsp_item_in.out_vlan       = rd_data.vlan;
                     rsp_item_in.out_group      = rd_data.group;
                     rsp_item_in.out_source     = rd_data.source;
                     rsp_item_in.out_assured_bw = rd_data.assured_bw;
                     rsp_item_in.out_peak_bw    = rd_data.peak_bw;
                  end
               end
               mgct_pkg::CMD_VLAN_BY_GRP: begin
                  rsp_item_in.ok       = found_ff;
                  rsp_item_in.out_vlan = found_ff ? found_vlan_ff : 12'd0;
               end
               mgct_pkg::CMD_EXISTS: begin
                  rsp_item_in.ok = found_ff && (found_vlan_ff == req_ff.vlan_id);
               end
               mgct_pkg::CMD_VLAN_USED: begin
                  rsp_item_in.ok = found_ff;
               end
               mgct_pkg::CMD_GRP_CONFL: begin
                  rsp_item_in.ok = found_ff;
               end
            endcase
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_issued_ff <= 1'b0;
         data_vld_ff    <= 1'b0;
         found_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         for (int i = 0; i < mgct_pkg::TABLE_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff       <= state_in;
         last_issued_ff <= last_issued_in;
         data_vld_ff    <= data_vld_in;
         found_ff       <= found_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         valid_ff       <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      scan_idx_ff   <= scan_idx_in;
      data_idx_ff   <= data_idx_in;
      found_vlan_ff <= found_vlan_in;
      rsp_item_ff   <= rsp_item_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
